// File: rtl/assert_macros.svh
// assertion macros shared by the value list store rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define VLS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// same check on the usual clock and reset port names
`define VLS_ASSERT(lbl, prop, msg) `VLS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/vls_pkg.sv
// value list store package: opcode and status codes, result record
// no dependencies
`default_nettype none

package vls_pkg;

    localparam int VAL_W     = 32;
    localparam int OPC_W     = 3;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT       = 3'd0,
        OP_REMOVE_FIRST = 3'd1,
        OP_FIND         = 3'd2,
        OP_REMOVE_VALUE = 3'd3,
        OP_CLEAR        = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [POS_W-1:0]       position;
        logic [CNT_OUT_W-1:0]   entry_count;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/value_list_store_top.sv
// value list store top level: entry ram plus sequencer
// depends on vls_pkg, vls_ram and vls_ctrl
`default_nettype none

// Bounded list of signed 32-bit values, newest first, held oldest-first in one
// ram of LIST_DEPTH entries; the front of the list is the highest filled slot.
// Pulse start while busy is low to hand in an item. Every item gives exactly one
// result, shown for one cycle with o_done high; the receiver cannot stall it.
// Insert, remove first, clear and unused opcodes give their result the cycle
// after the item and leave busy low, so items may follow back to back. Find
// walks the list from the front, one entry per cycle through the single ram
// read port, and stops at the first match or after the last entry.
// Remove value adds the shift-down walk, one entry per cycle, which closes the
// gap left by a match below the front.
// No clearing pass after reset.
module value_list_store_top import vls_pkg::*; #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OPC_W-1:0]         i_opcode,
    input  wire logic signed [VAL_W-1:0]  i_item_value,
    output logic                          o_done,
    output logic [STAT_W-1:0]             o_status,
    output logic [POS_W-1:0]              o_position,
    output logic [CNT_OUT_W-1:0]          o_entry_count
);

    localparam int AW = $clog2(LIST_DEPTH);

    logic              w_req;
    logic [VAL_W-1:0]  w_value;
    logic              w_busy;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [VAL_W-1:0]  w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [VAL_W-1:0]  w_mem_rdata;

    assign w_req   = start & ~w_busy;
    assign w_value = $unsigned(i_item_value);

    vls_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_opcode    (i_opcode),
        .i_value     (w_value),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    vls_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LIST_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign busy          = w_busy;
    assign o_done        = w_res_valid;
    assign o_status      = w_res.status;
    assign o_position    = w_res.position;
    assign o_entry_count = w_res.entry_count;

endmodule

`default_nettype wire

// File: rtl/vls_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module vls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/vls_ctrl.sv
// value list store sequencer: count register, scan compare and shift-down walk
// depends on vls_pkg and assert_macros.svh; drives the entry ram ports
`default_nettype none
`include "assert_macros.svh"

module vls_ctrl import vls_pkg::*; #(
    parameter int LIST_DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req,
    input  wire logic [OPC_W-1:0]              i_opcode,
    input  wire logic [VAL_W-1:0]              i_value,
    output logic                               o_busy,
    output logic                               o_res_valid,
    output t_result                            o_res,
    output logic                               o_mem_we,
    output logic [$clog2(LIST_DEPTH)-1:0]      o_mem_waddr,
    output logic [VAL_W-1:0]                   o_mem_wdata,
    output logic                               o_mem_re,
    output logic [$clog2(LIST_DEPTH)-1:0]      o_mem_raddr,
    input  wire logic [VAL_W-1:0]              i_mem_rdata
);

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state          r_state,    n_state;
    logic [CW-1:0]   r_count,    n_count;
    t_opcode         r_op,       n_op;
    logic [VAL_W-1:0] r_value,   n_value;
    logic [AW-1:0]   r_cmp_addr, n_cmp_addr;
    logic [AW-1:0]   r_cmp_pos,  n_cmp_pos;
    logic [AW-1:0]   r_wr_addr,  n_wr_addr;
    logic            r_res_valid, n_res_valid;
    t_result         r_res,      n_res;
    logic            match;

    assign match = (i_mem_rdata == r_value);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_value     = r_value;
        n_cmp_addr  = r_cmp_addr;
        n_cmp_pos   = r_cmp_pos;
        n_wr_addr   = r_wr_addr;
        n_res_valid = 1'b0;
        n_res       = r_res;
        n_res.status   = ST_OK;
        n_res.position = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_count);
        o_mem_wdata = i_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cmp_addr;

        unique case (r_state)
            S_IDLE: begin
                if (i_req) begin
                    n_op        = t_opcode'(i_opcode);
                    n_value     = i_value;
                    n_res_valid = 1'b1;
                    unique case (t_opcode'(i_opcode))
                        OP_INSERT: begin
                            if (r_count == CW'(LIST_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_REMOVE_FIRST: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_FIND, OP_REMOVE_VALUE: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_res_valid = 1'b0;
                                o_mem_re    = 1'b1;
                                o_mem_raddr = AW'(r_count - 1'b1);
                                n_cmp_addr  = AW'(r_count - 1'b1);
                                n_cmp_pos   = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    if (r_op == OP_FIND) begin
                        n_res_valid    = 1'b1;
                        n_res.position = POS_W'(r_cmp_pos);
                        n_state        = S_IDLE;
                    end else if (r_cmp_pos == '0) begin
                        n_count     = r_count - 1'b1;
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_cmp_addr + 1'b1;
                        n_wr_addr   = r_cmp_addr;
                        n_state     = S_SHIFT;
                    end
                end else if (r_cmp_addr == '0) begin
                    n_res_valid  = 1'b1;
                    n_res.status = ST_MISSING;
                    n_state      = S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_cmp_addr - 1'b1;
                    n_cmp_addr  = r_cmp_addr - 1'b1;
                    n_cmp_pos   = r_cmp_pos + 1'b1;
                end
            end
            S_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wr_addr;
                o_mem_wdata = i_mem_rdata;
                if (CW'(r_wr_addr) + CW'(2) == r_count) begin
                    n_count     = r_count - 1'b1;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_wr_addr + AW'(2);
                    n_wr_addr   = r_wr_addr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.entry_count = CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_op       <= n_op;
        r_value    <= n_value;
        r_cmp_addr <= n_cmp_addr;
        r_cmp_pos  <= n_cmp_pos;
        r_wr_addr  <= n_wr_addr;
        r_res      <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `VLS_ASSERT(a_count_bound, r_count <= CW'(LIST_DEPTH), "count above list depth")
    `VLS_ASSERT(a_res_when_idle, r_res_valid |-> (r_state == S_IDLE), "result while walking")
    `VLS_ASSERT(a_shift_in_range, (r_state == S_SHIFT) |-> (CW'(r_wr_addr) + CW'(2) <= r_count), "shift past top")
    `VLS_ASSERT(a_full_flag, (r_res_valid && (r_res.status == ST_FULL)) |-> (r_count == CW'(LIST_DEPTH)), "full flag with room left")

endmodule

`default_nettype wire

// File: tb/value_list_store_top_tb.sv
// testbench for value_list_store_top: directed table, then biased random list operations
// depends on vls_pkg and the value list store rtl; results checked against the directed table or a shadow list
`default_nettype none

module value_list_store_top_tb;
    import vls_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SEGMENT_LEN  = 150;
    localparam int MAX_GAP      = 17;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_CYC  = 1_200_000;

    localparam logic [OPC_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OPC_W-1:0] OP_RSVD_MID = 3'd6;
    localparam logic [OPC_W-1:0] OP_RSVD_HI = 3'd7;

    typedef struct {
        logic [OPC_W-1:0] op;
        logic [VAL_W-1:0] val;
        int               reps;
        bit               known;
        t_result          want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OPC_W-1:0]      i_opcode = '0;
    logic [VAL_W-1:0]      i_item_value = '0;
    logic                  o_done;
    logic [STAT_W-1:0]     o_status;
    logic [POS_W-1:0]      o_position;
    logic [CNT_OUT_W-1:0]  o_entry_count;

    logic [VAL_W-1:0] shadow_vals [LIST_DEPTH];
    int               shadow_count = 0;
    t_result          pending_results [$];
    int               err_count = 0;

    int ins_pct_by_mode [3] = '{70, 40, 20};
    int clr_pct_by_mode [3] = '{0, 3, 6};

    t_dir_row directed_ops [25] = '{
        '{OP_REMOVE_FIRST, 32'h0000_0000, 1, 1'b1, '{ST_EMPTY,   6'd0,  7'd0}},
        '{OP_FIND,         32'h0000_0005, 1, 1'b1, '{ST_EMPTY,   6'd0,  7'd0}},
        '{OP_REMOVE_VALUE, 32'h0000_0005, 1, 1'b1, '{ST_EMPTY,   6'd0,  7'd0}},
        '{OP_INSERT,       32'h8000_0000, 1, 1'b1, '{ST_OK,      6'd0,  7'd1}},
        '{OP_INSERT,       32'h7fff_ffff, 1, 1'b1, '{ST_OK,      6'd0,  7'd2}},
        '{OP_INSERT,       32'hffff_ffff, 1, 1'b1, '{ST_OK,      6'd0,  7'd3}},
        '{OP_INSERT,       32'h0000_0000, 1, 1'b1, '{ST_OK,      6'd0,  7'd4}},
        '{OP_FIND,         32'h8000_0000, 1, 1'b1, '{ST_OK,      6'd3,  7'd4}},
        '{OP_FIND,         32'h0000_0000, 1, 1'b1, '{ST_OK,      6'd0,  7'd4}},
        '{OP_FIND,         32'h0000_3039, 1, 1'b1, '{ST_MISSING, 6'd0,  7'd4}},
        '{OP_REMOVE_VALUE, 32'hffff_ffff, 1, 1'b1, '{ST_OK,      6'd0,  7'd3}},
        '{OP_FIND,         32'h7fff_ffff, 1, 1'b1, '{ST_OK,      6'd1,  7'd3}},
        '{OP_REMOVE_VALUE, 32'h0000_0309, 1, 1'b1, '{ST_MISSING, 6'd0,  7'd3}},
        '{OP_RSVD_LO,      32'h5a5a_5a5a, 1, 1'b1, '{ST_OK,      6'd0,  7'd3}},
        '{OP_RSVD_HI,      32'ha5a5_a5a5, 1, 1'b1, '{ST_OK,      6'd0,  7'd3}},
        '{OP_REMOVE_FIRST, 32'hffff_ffff, 1, 1'b1, '{ST_OK,      6'd0,  7'd2}},
        '{OP_CLEAR,        32'h1234_5678, 1, 1'b1, '{ST_OK,      6'd0,  7'd0}},
        '{OP_FIND,         32'h0000_0000, 1, 1'b1, '{ST_EMPTY,   6'd0,  7'd0}},
        '{OP_INSERT,       32'h0000_0063, 1, 1'b1, '{ST_OK,      6'd0,  7'd1}},
        '{OP_INSERT,       32'h0000_002a, 63, 1'b0, '{ST_OK,     6'd0,  7'd0}},
        '{OP_INSERT,       32'h0000_0001, 1, 1'b1, '{ST_FULL,    6'd0,  7'd64}},
        '{OP_FIND,         32'h0000_0063, 1, 1'b1, '{ST_OK,      6'd63, 7'd64}},
        '{OP_REMOVE_VALUE, 32'h0000_002a, 1, 1'b1, '{ST_OK,      6'd0,  7'd63}},
        '{OP_REMOVE_VALUE, 32'h0000_0063, 1, 1'b1, '{ST_OK,      6'd0,  7'd62}},
        '{OP_CLEAR,        32'h0000_0000, 1, 1'b1, '{ST_OK,      6'd0,  7'd0}}
    };

    value_list_store_top #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_item_value  (i_item_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    // position from the front of the first match, -1 on a miss
    function automatic int front_match_pos(logic [VAL_W-1:0] val);
        for (int p = 0; p < shadow_count; p++) begin
            if (shadow_vals[shadow_count - 1 - p] == val) begin
                return p;
            end
        end
        return -1;
    endfunction

    function automatic t_result apply_list_op(logic [OPC_W-1:0] op, logic [VAL_W-1:0] val);
        t_result r;
        int      hit;
        r.status   = ST_OK;
        r.position = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_vals[shadow_count] = val;
                    shadow_count++;
                end
            end
            OP_REMOVE_FIRST: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_count--;
            end
            OP_FIND, OP_REMOVE_VALUE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hit = front_match_pos(val);
                    if (hit < 0) begin
                        r.status = ST_MISSING;
                    end else if (op == OP_FIND) begin
                        r.position = hit[POS_W-1:0];
                    end else begin
                        for (int s = shadow_count - 1 - hit; s + 1 < shadow_count; s++) begin
                            shadow_vals[s] = shadow_vals[s + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            OP_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.entry_count = shadow_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    // half the draws take a value already held, when there is one, so finds and removals hit
    function automatic logic [VAL_W-1:0] draw_value();
        int r;
        r = $urandom_range(99);
        if (r < 50 && shadow_count > 0) return shadow_vals[$urandom_range(shadow_count - 1)];
        if (r < 65) return $urandom;
        return VAL_W'($signed($urandom_range(15)) - 8);
    endfunction

    task automatic issue_item(input logic [OPC_W-1:0] op, input logic [VAL_W-1:0] val,
                              input int gap, input bit known, input t_result want);
        t_result predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_item_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_list_op(op, val);
        pending_results.push_back(known ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d position %0d count %0d",
                             o_status, o_position, o_entry_count);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status != exp_r.status || o_position != exp_r.position ||
                    o_entry_count != exp_r.entry_count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: expected status %0d position %0d count %0d, got %0d %0d %0d",
                                 exp_r.status, exp_r.position, exp_r.entry_count,
                                 o_status, o_position, o_entry_count);
                end
            end
        end
    end

    initial begin
        int                mode;
        bit                idle_on;
        int                r;
        logic [OPC_W-1:0]  op;
        t_result           none;
        none = '{ST_OK, '0, '0};
        idle_on = 1'b1;
        mode = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[k]) begin
            for (int n = 0; n < directed_ops[k].reps; n++) begin
                issue_item(directed_ops[k].op, directed_ops[k].val,
                           $urandom_range(MAX_GAP), directed_ops[k].known, directed_ops[k].want);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % SEGMENT_LEN == 0) begin
                mode    = $urandom_range(2);
                idle_on = ($urandom_range(3) != 0);
            end
            r = $urandom_range(99);
            if (r < ins_pct_by_mode[mode]) begin
                op = OP_INSERT;
            end else begin
                r = $urandom_range(99);
                if (r < 20) op = OP_REMOVE_FIRST;
                else if (r < 55) op = OP_FIND;
                else if (r < 90) op = OP_REMOVE_VALUE;
                else if (r < 90 + clr_pct_by_mode[mode]) op = OP_CLEAR;
                else op = OPC_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
            end
            issue_item(op, draw_value(), idle_on ? $urandom_range(MAX_GAP) : 0, 1'b0, none);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * LIST_DEPTH + 8) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #(20 * TIMEOUT_CYC);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/vls_pkg.sv
rtl/vls_ram.sv
rtl/vls_ctrl.sv
rtl/value_list_store_top.sv
tb/value_list_store_top_tb.sv
